FILE: rtl/tmcw_pkg.sv
// tmcw_pkg: shared types and constants for the text-mode console writer.
// Used by tmcw_cell_ram and text_mode_console_writer_core; no dependencies.
`default_nettype none

package tmcw_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CLR_W  = 4;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IDX_W  = 13;  // row * columns + column for any register setting
  localparam int unsigned LIN_W  = 11;  // cursor_linear field width

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SETPOS = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_FG      = 2'd2,
    REG_BG      = 2'd3
  } reg_e;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] ch;
  } cell_t;

endpackage

`default_nettype wire

FILE: rtl/text_mode_console_writer_core.sv
// text_mode_console_writer_core: console engine with cursor, wrap and scroll.
// Depends on tmcw_pkg and tmcw_cell_ram.
//
//   channel   | signals                                 | direction
//   ----------+-----------------------------------------+----------
//   s_axis    | tvalid, tready, tuser=cmd, tdata        | in
//   m_axis    | tvalid, tready, tdata                   | out
//   cfg       | valid, ready (always 1), index, data    | in
//
// put: exec (cell write), cell read, cell write, result, then back to idle
// for the next accept; newline without write takes the same path. set
// position: exec, result. read cell: exec, read wait, result. a scroll moves
// the cells up one row (one cell move per cycle through the ram read/write
// ports) and then clears the bottom row; a clear writes all columns*rows cells.
// after reset a clearing pass writes all MAX_COLUMNS*MAX_ROWS cells, one a
// cycle, with s_axis_tready low. the result register holds while m_axis stalls,
// and the next item is taken meanwhile.
`default_nettype none

module text_mode_console_writer_core #(
  parameter int unsigned MAX_COLUMNS = 80,
  parameter int unsigned MAX_ROWS    = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // char_code[7:0], column[14:8], row[19:15], zero
  input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // cursor_row[4:0], cursor_column[11:5],
                                           // cursor_linear[22:12], scrolled[23],
                                           // cell_char[31:24], cell_attr[39:32]
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);
  import tmcw_pkg::*;

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EXEC, S_RDWAIT, S_RMWRD, S_RMWWR,
    S_MOVE, S_BOTTOM, S_CLR, S_RESP
  } state_e;

  function automatic logic [IDX_W-1:0] lin_idx(logic [ROW_W-1:0] r,
                                               logic [COL_W-1:0] c,
                                               logic [COL_W-1:0] n);
    return IDX_W'(r) * IDX_W'(n) + IDX_W'(c);
  endfunction

  // configuration registers
  logic [COL_W-1:0] scr_cols_q;
  logic [ROW_W-1:0] scr_rows_q;
  logic [CLR_W-1:0] fg_q, bg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_cols_q <= 7'd80;
      scr_rows_q <= 5'd25;
      fg_q       <= 4'd7;
      bg_q       <= 4'd0;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_COLUMNS: scr_cols_q <= cfg_data_i;
        REG_ROWS:    scr_rows_q <= cfg_data_i[ROW_W-1:0];
        REG_FG:      fg_q       <= cfg_data_i[CLR_W-1:0];
        REG_BG:      bg_q       <= cfg_data_i[CLR_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry in use
  logic [COL_W-1:0]  cols_w;
  logic [ROW_W-1:0]  rows_w;
  logic [ATTR_W-1:0] attr_w;

  always_comb begin
    priority if (scr_cols_q == '0)              cols_w = COL_W'(1);
    else if (32'(scr_cols_q) > MAX_COLUMNS)     cols_w = COL_W'(MAX_COLUMNS);
    else                                        cols_w = scr_cols_q;
    priority if (scr_rows_q == '0)              rows_w = ROW_W'(1);
    else if (32'(scr_rows_q) > MAX_ROWS)        rows_w = ROW_W'(MAX_ROWS);
    else                                        rows_w = scr_rows_q;
  end

  assign attr_w = {bg_q, fg_q};

  // registers
  state_e           state_q;
  logic [AW-1:0]    init_q;
  cmd_e             cmd_q;
  logic [CHAR_W-1:0] ch_q;
  logic [ROW_W-1:0] cur_row_q, pos_row_q;
  logic [COL_W-1:0] cur_col_q, pos_col_q;
  logic             scrolled_q;
  cell_t            cell_q;
  logic [IDX_W-1:0] cnt_q, span_q;
  logic             pend_q;
  logic [AW-1:0]    wa_q;
  logic             out_valid_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q;
  logic [LIN_W-1:0] out_lin_q;
  logic             out_scrolled_q;
  cell_t            out_cell_q;

  // incoming fields
  logic [CHAR_W-1:0] in_char;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  assign in_char = s_axis_tdata[7:0];
  assign in_col  = s_axis_tdata[14:8];
  assign in_row  = s_axis_tdata[19:15];

  assign s_axis_tready = (state_q == S_IDLE);

  // put: cursor advance
  logic             is_nl;
  logic [COL_W-1:0] c1, c2;
  logic [ROW_W:0]   r1, r2;
  logic             wrap, do_scroll;

  always_comb begin
    is_nl     = (ch_q == NEWLINE_CODE);
    c1        = is_nl ? '0 : cur_col_q + COL_W'(1);
    r1        = is_nl ? {1'b0, cur_row_q} + (ROW_W+1)'(1) : {1'b0, cur_row_q};
    wrap      = (c1 >= cols_w);
    c2        = wrap ? '0 : c1;
    r2        = wrap ? r1 + (ROW_W+1)'(1) : r1;
    do_scroll = (r2 >= {1'b0, rows_w});
  end

  // addresses
  logic [IDX_W-1:0] exec_idx, cur_idx, span_w, bottom_end;
  logic [ROW_W-1:0] span_rows;

  assign exec_idx   = (cmd_q == CMD_READ) ? lin_idx(pos_row_q, pos_col_q, cols_w)
                                          : lin_idx(cur_row_q, cur_col_q, cols_w);
  assign cur_idx    = lin_idx(cur_row_q, cur_col_q, cols_w);
  assign span_rows  = (cmd_q == CMD_CLEAR) ? rows_w : rows_w - ROW_W'(1);
  assign span_w     = IDX_W'(cols_w) * IDX_W'(span_rows);
  assign bottom_end = span_q + IDX_W'(cols_w);

  // ram port control
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  cell_t         ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_q;
      end
      S_EXEC: begin
        if (cmd_q == CMD_PUT && !is_nl) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(exec_idx);
          ram_wdata = '{attr: attr_w, ch: ch_q};
        end
        if (cmd_q == CMD_READ) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(exec_idx);
        end
      end
      S_RMWRD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(cur_idx);
      end
      S_RMWWR: begin
        ram_we    = 1'b1;
        ram_waddr = wa_q;
        ram_wdata = '{attr: attr_w, ch: ram_rdata.ch};
      end
      S_MOVE: begin
        // read one row ahead, write the previous read back one row up
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata;
        end
        if (cnt_q < span_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(cnt_q + IDX_W'(cols_w));
        end
      end
      S_BOTTOM: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt_q);
        ram_wdata = (cnt_q == span_q) ? cell_t'{attr: attr_w, ch: '0} : cell_t'('0);
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt_q);
        ram_wdata = (cnt_q == '0) ? cell_t'{attr: attr_w, ch: '0} : cell_t'('0);
      end
      default: ;
    endcase
  end

  tmcw_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_INIT;
      init_q         <= '0;
      cmd_q          <= CMD_PUT;
      ch_q           <= '0;
      cur_row_q      <= '0;
      cur_col_q      <= '0;
      pos_row_q      <= '0;
      pos_col_q      <= '0;
      scrolled_q     <= 1'b0;
      cell_q         <= '0;
      cnt_q          <= '0;
      span_q         <= '0;
      pend_q         <= 1'b0;
      wa_q           <= '0;
      out_valid_q    <= 1'b0;
      out_row_q      <= '0;
      out_col_q      <= '0;
      out_lin_q      <= '0;
      out_scrolled_q <= 1'b0;
      out_cell_q     <= '0;
    end else begin
      // in S_RESP a taken result is replaced by the new one below
      if (out_valid_q && m_axis_tready && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + AW'(1);
          if (init_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q     <= cmd_e'(s_axis_tuser);
            ch_q      <= in_char;
            // cursor left outside a shrunk geometry snaps to the last column and/or row
            cur_col_q <= (cur_col_q >= cols_w) ? cols_w - COL_W'(1) : cur_col_q;
            cur_row_q <= (cur_row_q >= rows_w) ? rows_w - ROW_W'(1) : cur_row_q;
            pos_col_q <= (in_col >= cols_w) ? cols_w - COL_W'(1) : in_col;
            pos_row_q <= (in_row >= rows_w) ? rows_w - ROW_W'(1) : in_row;
            state_q   <= S_EXEC;
          end
        end
        S_EXEC: begin
          scrolled_q <= (cmd_q == CMD_PUT) && do_scroll;
          cell_q     <= '0;
          cnt_q      <= '0;
          pend_q     <= 1'b0;
          span_q     <= span_w;
          unique case (cmd_q)
            CMD_PUT: begin
              if (do_scroll) begin
                cur_row_q  <= rows_w - ROW_W'(1);
                cur_col_q  <= '0;
                state_q    <= S_MOVE;
              end else begin
                cur_row_q <= r2[ROW_W-1:0];
                cur_col_q <= c2;
                state_q   <= S_RMWRD;
              end
            end
            CMD_CLEAR: begin
              cur_row_q <= '0;
              cur_col_q <= '0;
              state_q   <= S_CLR;
            end
            CMD_SETPOS: begin
              cur_row_q <= pos_row_q;
              cur_col_q <= pos_col_q;
              state_q   <= S_RESP;
            end
            CMD_READ: begin
              state_q <= S_RDWAIT;
            end
            default: ;
          endcase
        end
        S_RDWAIT: begin
          cell_q  <= ram_rdata;
          state_q <= S_RESP;
        end
        S_RMWRD: begin
          wa_q    <= AW'(cur_idx);
          state_q <= S_RMWWR;
        end
        S_RMWWR: begin
          state_q <= S_RESP;
        end
        S_MOVE: begin
          if (cnt_q < span_q) begin
            pend_q <= 1'b1;
            wa_q   <= AW'(cnt_q);
            cnt_q  <= cnt_q + IDX_W'(1);
          end else begin
            pend_q  <= 1'b0;
            state_q <= S_BOTTOM;
          end
        end
        S_BOTTOM: begin
          cnt_q <= cnt_q + IDX_W'(1);
          if (cnt_q + IDX_W'(1) == bottom_end) begin
            state_q <= S_RESP;
          end
        end
        S_CLR: begin
          cnt_q <= cnt_q + IDX_W'(1);
          if (cnt_q + IDX_W'(1) == span_q) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q    <= 1'b1;
            out_row_q      <= cur_row_q;
            out_col_q      <= cur_col_q;
            out_lin_q      <= cur_idx[LIN_W-1:0];
            out_scrolled_q <= scrolled_q;
            out_cell_q     <= cell_q;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cell_q.attr, out_cell_q.ch, out_scrolled_q,
                          out_lin_q, out_col_q, out_row_q};

`ifndef ASSERT_OFF
  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !out_valid_q)
    else $error("result presented during clearing pass");

  a_ram_ports_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram read and write hit the same cell");

  a_scroll_home_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_scrolled_q) |-> (out_col_q == '0))
    else $error("scrolled result with cursor off the first column");

  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RMWWR) |-> $past(state_q == S_RMWRD))
    else $error("attribute write-back without preceding cell read");
`endif

endmodule

`default_nettype wire

FILE: rtl/tmcw_cell_ram.sv
// tmcw_cell_ram: character-cell buffer, one write port and one read port,
// read data registered. Depends on tmcw_pkg for the cell type.
`default_nettype none

module tmcw_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire tmcw_pkg::cell_t wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output tmcw_pkg::cell_t      rdata_o
);
  import tmcw_pkg::*;

  cell_t mem_q [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
